@@ hw/rtl/idal_pkg.sv @@
// ----------------------------------------------------------------------------
// idal_pkg
// shared types and constants of the identifier allocator
// ----------------------------------------------------------------------------
package idal_pkg;

	// identifier field width, fixed by the word format
	localparam int ID_W = 8;
	// largest id space the 8-bit fields can address
	localparam int ID_LIMIT = 1 << ID_W;
	// default size of the id space
	localparam int MAX_IDS_DEF = 256;

	typedef enum logic {
		OP_RESERVE = 1'b0,
		OP_FREE    = 1'b1
	} idal_op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EXHAUSTED = 2'd1,
		STAT_RANGE     = 2'd2,
		STAT_FULL      = 2'd3
	} idal_status_t;

	typedef struct packed {
		idal_op_t          opcode;
		logic [ID_W-1:0]   wanted_id;
	} idal_req_t;

	typedef struct packed {
		logic [ID_W-1:0]   granted_id;
		idal_status_t      status;
	} idal_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT,
		S_FILL,
		S_POST
	} idal_state_t;

endpackage

@@ hw/rtl/idal_stream_if.sv @@
// ----------------------------------------------------------------------------
// idal_stream_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface idal_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/idal_ram.sv @@
// ----------------------------------------------------------------------------
// idal_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module idal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/id_allocator_free_list.sv @@
// ----------------------------------------------------------------------------
// id_allocator_free_list
// hands out and takes back identifiers from an ordered free list in ram
// ----------------------------------------------------------------------------
// flow: a free or an out-of-range word goes from accept through S_POST to the
//   output register; a reserve scans the list one ram read per cycle, then
//   shifts the tail down or appends skipped ids one per cycle (one ram port)
// throughput: one request at a time; the next is taken once the answer sits in
//   the output register, which waits there for the consumer
// reset: arst_n clears list count, fresh counter, fsm and output valid; the list ram is not
// ----------------------------------------------------------------------------
module id_allocator_free_list
	import idal_pkg::*;
#(
	parameter int MAX_IDS = MAX_IDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	idal_stream_if.sink   req,
	idal_stream_if.source rsp
);
	// id space is capped by what the 8-bit id field can carry
	localparam int ID_SPACE = (MAX_IDS < ID_LIMIT) ? MAX_IDS : ID_LIMIT;
	localparam int IW = $clog2(ID_SPACE);     // list index width
	localparam int CW = $clog2(ID_SPACE + 1); // count / counter width
	localparam logic [CW-1:0] CNT_FULL = CW'(ID_SPACE);
	localparam logic [ID_W:0] ID_TOP = (ID_W + 1)'(ID_SPACE);
	// wide enough for count plus a skip distance
	localparam int AW = ID_W + 2;

	idal_state_t     state_q, state_d;
	logic [CW-1:0]   count_q, count_d;   // valid entries in the list
	logic [CW-1:0]   fresh_q, fresh_d;   // lowest id never handed out
	logic [CW-1:0]   fill_q, fill_d;     // next skipped id to append
	logic [IW-1:0]   idx_q, idx_d;       // scan position, then shift target
	logic [ID_W-1:0] id_q, id_d;         // wanted id of the current request
	logic [ID_W-1:0] head_q, head_d;     // list head seen during the scan
	idal_rsp_t       res_q, res_d;       // answer waiting for the output reg
	idal_rsp_t       out_q;
	logic            out_vld_q;
	logic            load_out;

	// ram port
	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	logic [ID_W-1:0] ram_wdata;
	logic [IW-1:0]   ram_raddr;
	logic [ID_W-1:0] ram_rdata;

	// helper terms
	logic            in_range;
	logic            scan_last;
	logic            shift_last;
	logic [IW-1:0]   idx_nx;
	logic [AW-1:0]   id_ext;
	logic [AW-1:0]   fresh_ext;
	logic [AW-1:0]   cnt_ext;
	logic [AW-1:0]   need_ext;
	logic            skip_ok;

	idal_ram #(
		.WIDTH (ID_W),
		.DEPTH (ID_SPACE)
	) u_list (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_range  = {1'b0, req.data.wanted_id} < ID_TOP;
	assign idx_nx    = idx_q + 1'b1;
	// scan reached the last valid entry
	assign scan_last  = (CW'(idx_q) + CW'(1)) == count_q;
	// the entry being moved down is the last valid one
	assign shift_last = (CW'(idx_q) + CW'(2)) == count_q;
	assign id_ext    = AW'(id_q);
	assign fresh_ext = AW'(fresh_q);
	assign cnt_ext   = AW'(count_q);
	// list length once the skipped ids below the wanted id are appended
	assign need_ext  = cnt_ext + (id_ext - fresh_ext);
	assign skip_ok   = need_ext <= AW'(ID_SPACE);

	// ------------------------------------------------------------------
	// sequencer: next state, ram accesses and bookkeeping
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		fresh_d   = fresh_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		id_d      = id_q;
		head_d    = head_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = count_q[IW-1:0];
		ram_wdata = req.data.wanted_id;
		ram_raddr = idx_nx;
		req.ready = 1'b0;
		load_out  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				ram_raddr = '0;
				if (req.valid) begin
					id_d = req.data.wanted_id;
					if (!in_range) begin
						res_d   = '{granted_id: '0, status: STAT_RANGE};
						state_d = S_POST;
					end else if (req.data.opcode == OP_FREE) begin
						if (count_q == CNT_FULL) begin
							// list full, the free is dropped
							res_d = '{granted_id: '0, status: STAT_FULL};
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + 1'b1;
							res_d   = '{granted_id: '0, status: STAT_OK};
						end
						state_d = S_POST;
					end else if (count_q == '0) begin
						state_d = S_DECIDE;
					end else begin
						// first read of the scan goes out now
						idx_d   = '0;
						state_d = S_SEARCH;
					end
				end
			end

			S_SEARCH: begin
				// ram_rdata holds entry idx_q, entry idx_q+1 is being read
				if (idx_q == '0) begin
					head_d = ram_rdata;
				end
				if (ram_rdata == id_q) begin
					res_d = '{granted_id: id_q, status: STAT_OK};
					if (scan_last) begin
						count_d = count_q - 1'b1;
						state_d = S_POST;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (scan_last) begin
					state_d = S_DECIDE;
				end else begin
					idx_d = idx_nx;
				end
			end

			S_DECIDE: begin
				if (fresh_ext <= id_ext) begin
					if (!skip_ok) begin
						res_d   = '{granted_id: '0, status: STAT_FULL};
						state_d = S_POST;
					end else begin
						res_d = '{granted_id: id_q, status: STAT_OK};
						if (fresh_ext == id_ext) begin
							fresh_d = CW'(id_ext + AW'(1));
							state_d = S_POST;
						end else begin
							fill_d  = fresh_q;
							state_d = S_FILL;
						end
					end
				end else if (count_q == '0) begin
					if (fresh_q == CNT_FULL) begin
						res_d = '{granted_id: '0, status: STAT_EXHAUSTED};
					end else begin
						res_d   = '{granted_id: ID_W'(fresh_q), status: STAT_OK};
						fresh_d = fresh_q + 1'b1;
					end
					state_d = S_POST;
				end else begin
					// grant the head and close the gap at entry zero
					res_d = '{granted_id: head_q, status: STAT_OK};
					if (count_q == CW'(1)) begin
						count_d = '0;
						state_d = S_POST;
					end else begin
						idx_d   = '0;
						state_d = S_SHIFT_RD;
					end
				end
			end

			S_SHIFT_RD: begin
				state_d = S_SHIFT;
			end

			S_SHIFT: begin
				// move entry idx_q+1 (now in ram_rdata) down to idx_q
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				ram_raddr = idx_nx + 1'b1;
				if (shift_last) begin
					count_d = count_q - 1'b1;
					state_d = S_POST;
				end else begin
					idx_d = idx_nx;
				end
			end

			S_FILL: begin
				// append skipped ids from the fresh counter up to id - 1
				ram_we    = 1'b1;
				ram_wdata = ID_W'(fill_q);
				count_d   = count_q + 1'b1;
				fill_d    = fill_q + 1'b1;
				if ((AW'(fill_q) + AW'(1)) == id_ext) begin
					fresh_d = CW'(id_ext + AW'(1));
					state_d = S_POST;
				end
			end

			S_POST: begin
				if (!out_vld_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			fresh_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			fresh_q <= fresh_d;
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		fill_q <= fill_d;
		idx_q  <= idx_d;
		id_q   <= id_d;
		head_q <= head_d;
		res_q  <= res_d;
	end

	// ------------------------------------------------------------------
	// output register: holds the answer word until it is taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

`ifndef SYNTHESIS
	// list never holds more entries than the id space
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("free list count beyond id space");

	// fresh counter never passes the id space
	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CNT_FULL)
		else $error("fresh counter beyond id space");

	// appends only happen while there is room in the list
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (state_q != S_SHIFT) |-> count_q != CNT_FULL)
		else $error("append into a full free list");

	// a finished answer waits while the output word is still pending
	a_post_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST) && out_vld_q && !rsp.ready |=> state_q == S_POST)
		else $error("answer dropped while output word pending");
`endif
endmodule
